/* rtl/pmst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_pkg: shared types and constants for the dense Prim tree block
// Sizes, item kinds, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package pmst_pkg;
	localparam int MAX_VERTICES = 32;
	localparam int WEIGHT_BITS  = 16;
	localparam int VB           = $clog2(MAX_VERTICES);
	localparam int CB           = VB + 1;
	localparam int TB           = 21;
	localparam int PAIRS        = MAX_VERTICES * MAX_VERTICES;
	localparam int AB           = 2 * VB;
	localparam logic [TB-1:0] TOTAL_MAX = {TB{1'b1}};

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_RUN   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	localparam logic [0:0] REG_VCOUNT = 1'b0;
	localparam logic [0:0] REG_START  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WR2, ST_CLR, ST_INIT, ST_SCAN, ST_LAST, ST_DECIDE, ST_EMIT,
		ST_WAIT
	} state_t;

	// candidate compare request to the shared unit
	typedef struct packed {
		logic                   valid;
		logic [WEIGHT_BITS-1:0] w;
		logic [VB-1:0]          j;
	} cand_t;
endpackage
`default_nettype wire

/* rtl/pmst_min_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_min_unit: shared running minimum
// One weight compare per cycle; keeps the first strictly smaller candidate.
// ----------------------------------------------------------------------------
module pmst_min_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            clear,
	input  wire pmst_pkg::cand_t                 cand,
	output logic                                 found,
	output logic [pmst_pkg::WEIGHT_BITS-1:0]     best,
	output logic [pmst_pkg::VB-1:0]              pick
);
	import pmst_pkg::*;
	logic take;
	assign take = cand.valid && (!found || cand.w < best);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (clear) begin
			found <= 1'b0;
		end else if (take) begin
			found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clear) begin
			best <= cand.w;
			pick <= cand.j;
		end
	end
endmodule
`default_nettype wire

/* rtl/prim_mst_dense.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prim_mst_dense: Prim minimum spanning tree on a dense weight matrix
// Edge store in block memory, sequencer walks it through one compare unit.
// ----------------------------------------------------------------------------
// Write: two memory writes, one per direction. Clear: all 1024 pairs, one pair per cycle.
// Run: the start beat is raised from ST_INIT, then each grow step makes tree_size*vertex_count
//   memory reads through the single read port, followed by ST_LAST, ST_DECIDE, ST_EMIT
//   and ST_WAIT. A result beat is held in an output register until taken.
// Reset (arst_n low, async) resets control and regs, then a clearing pass marks every
// pair empty before the first beat is taken.
module prim_mst_dense (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [1:0]  s_tuser,   // kind
	input  wire logic [31:0] s_tdata,   // vertex_a[4:0], vertex_b[9:5], weight[25:10]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // vertex[4:0], edge_weight[20:5], total_weight[41:21]
	output logic             m_tlast,
	output logic             m_tuser,   // error
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import pmst_pkg::*;

	logic [5:0]  vcount_q;
	logic [4:0]  start_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 6'd1;
			start_q  <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_VCOUNT) vcount_q <= pwdata[5:0];
			else                        start_q  <= pwdata[4:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_VCOUNT) prdata[5:0] = vcount_q;
		else                        prdata[4:0] = start_q;
	end

	state_t state_q, state_d;
	// each entry: {present, weight}
	logic [WEIGHT_BITS:0]   wmem [PAIRS];
	logic [AB-1:0]          clr_q;
	logic [MAX_VERTICES-1:0] in_tree_q;
	logic [VB-1:0]          order_q [MAX_VERTICES];
	logic [CB-1:0]          size_q, n_q, i_q;
	logic [VB-1:0]          j_q, a_q, b_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [WEIGHT_BITS:0]   rd_s1;
	logic [TB-1:0]          sum_q;
	logic                   rdv_s1, rdok_s1;
	logic [VB-1:0]          rdj_s1;

	kind_t kind;
	assign kind = kind_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	logic acc;
	assign acc = s_tvalid && s_tready;

	// output register
	logic            ov_q, olast_q, oerr_q;
	logic [VB-1:0]   ovtx_q;
	logic [WEIGHT_BITS-1:0] ow_q;
	logic [TB-1:0]   otot_q;
	assign m_tvalid = ov_q;
	assign m_tdata  = {6'd0, otot_q, ow_q, ovtx_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = oerr_q;

	// sequencer
	logic [VB-1:0] t_cur;
	assign t_cur = order_q[i_q[VB-1:0]];
	logic [AB-1:0] rd_addr;
	assign rd_addr = {t_cur, j_q};
	logic scan_rd;
	assign scan_rd = (state_q == ST_SCAN);

	cand_t cand;
	logic  mu_found, mu_clear;
	logic [WEIGHT_BITS-1:0] mu_best;
	logic [VB-1:0] mu_pick;
	assign cand.valid = rdv_s1 && rdok_s1 && rd_s1[WEIGHT_BITS];
	assign cand.w = rd_s1[WEIGHT_BITS-1:0];
	assign cand.j = rdj_s1;
	assign mu_clear = (state_q == ST_INIT) || (state_q == ST_EMIT);

	pmst_min_unit u_min (
		.clk(clk), .arst_n(arst_n), .clear(mu_clear), .cand(cand),
		.found(mu_found), .best(mu_best), .pick(mu_pick)
	);

	logic [CB-1:0] n_eff;
	assign n_eff = (vcount_q > 6'(MAX_VERTICES)) ? CB'(MAX_VERTICES) : CB'(vcount_q);
	logic scan_end;
	assign scan_end = (CB'(j_q) == n_q - 1'b1) && (i_q == size_q - 1'b1);
	logic [TB:0] sum_w;
	assign sum_w = {1'b0, sum_q} + (TB+1)'(mu_best);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc) begin
				unique case (kind)
					KIND_CLEAR: state_d = ST_CLR;
					KIND_WRITE: state_d = ST_WR2;
					KIND_RUN:   state_d = ST_INIT;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_WR2:    state_d = ST_IDLE;
			ST_CLR:    if (clr_q == {AB{1'b1}}) state_d = ST_IDLE;
			ST_INIT:   state_d = ST_WAIT;
			ST_SCAN:   if (scan_end) state_d = ST_LAST;
			ST_LAST:   state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_EMIT;
			ST_EMIT:   state_d = ST_WAIT;
			ST_WAIT:   if (!ov_q || m_tready) begin
				if (olast_q && ov_q) state_d = ST_IDLE;
				else if (!ov_q && olast_q) state_d = ST_IDLE;
				else state_d = ST_SCAN;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else         state_q <= state_d;
	end

	// weight memory: one write port, one registered read
	logic [AB-1:0] wr_addr;
	logic          wr_en;
	assign wr_en = (acc && kind == KIND_WRITE) || (state_q == ST_WR2) || (state_q == ST_CLR);
	assign wr_addr = (state_q == ST_CLR) ? clr_q :
		(state_q == ST_WR2) ? {b_q, a_q} :
		{s_tdata[VB-1:0], s_tdata[2*VB-1:VB]};
	logic [WEIGHT_BITS:0] wr_data;
	assign wr_data = (state_q == ST_CLR) ? '0 :
		(state_q == ST_WR2) ? {1'b1, w_q} : {1'b1, s_tdata[10 +: WEIGHT_BITS]};
	always_ff @(posedge clk) begin
		if (wr_en) wmem[wr_addr] <= wr_data;
		rd_s1 <= wmem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= scan_rd;
			// wraps back to zero at the end of the pass
			if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		rdok_s1 <= !in_tree_q[j_q] && (t_cur != j_q);
		rdj_s1  <= j_q;
	end

	// run control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; olast_q <= 1'b0; oerr_q <= 1'b0; in_tree_q <= '0;
			ovtx_q <= '0; ow_q <= '0; otot_q <= '0; order_q <= '{default: '0};
			a_q <= '0; b_q <= '0; w_q <= '0;
			size_q <= '0; sum_q <= '0; i_q <= '0; j_q <= '0; n_q <= '0;
		end else begin
			if (state_q == ST_INIT || state_q == ST_EMIT) ov_q <= 1'b1;
			else if (ov_q && m_tready)                      ov_q <= 1'b0;
			if (acc) begin
				a_q <= s_tdata[VB-1:0];
				b_q <= s_tdata[2*VB-1:VB];
				w_q <= s_tdata[10 +: WEIGHT_BITS];
			end
			unique case (state_q)
				ST_INIT: begin
					n_q <= n_eff; sum_q <= '0;
					i_q <= '0; j_q <= '0;
					ow_q <= '0; otot_q <= '0;
					if (n_eff == '0 || CB'(start_q) >= n_eff) begin
						in_tree_q <= '0;
						size_q <= '0; ovtx_q <= '0; olast_q <= 1'b1; oerr_q <= 1'b1;
					end else begin
						in_tree_q <= MAX_VERTICES'(1) << start_q;
						order_q[0] <= start_q;
						size_q <= CB'(1);
						ovtx_q <= start_q; oerr_q <= 1'b0;
						olast_q <= (n_eff == CB'(1));
					end
				end
				ST_SCAN: begin
					if (CB'(j_q) == n_q - 1'b1) begin
						j_q <= '0; i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_EMIT: begin
					i_q <= '0; j_q <= '0;
					if (!mu_found) begin
						ovtx_q <= '0; ow_q <= '0; otot_q <= sum_q;
						olast_q <= 1'b1; oerr_q <= 1'b1;
					end else begin
						in_tree_q[mu_pick] <= 1'b1;
						order_q[size_q[VB-1:0]] <= mu_pick;
						size_q <= size_q + 1'b1;
						sum_q  <= sum_w[TB] ? TOTAL_MAX : sum_w[TB-1:0];
						ovtx_q <= mu_pick; ow_q <= mu_best;
						otot_q <= sum_w[TB] ? TOTAL_MAX : sum_w[TB-1:0];
						olast_q <= (size_q + 1'b1 == n_q); oerr_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !s_tready)
		else $error("input accepted during scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |=> m_tvalid)
		else $error("emit did not raise a result beat");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result beat changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR2) |-> $past(acc))
		else $error("second write without an accepted beat");
endmodule
`default_nettype wire
